@@ rtl/core/midpoint_subdivision_line_clip_unit_macros.svh @@
// Assertion macros for the midpoint subdivision line clip unit.
`ifndef MIDPOINT_SUBDIVISION_LINE_CLIP_UNIT_MACROS_SVH
`define MIDPOINT_SUBDIVISION_LINE_CLIP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MSLC_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MSLC_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define MSLC_ASSERT_IMPL(label, clk, rst, prop, msg)
`define MSLC_ASSERT_NEXT(label, clk, rst, a, b, msg)
`endif
`endif

@@ rtl/core/mslc_pkg.sv @@
// Types and constants shared by the line clip unit.
package mslc_pkg;
  localparam int COORD_BITS = 16;
  localparam int CW = COORD_BITS;

  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_TOP    = 4'd8;

  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_BOTTOM = 3'd1;
  localparam logic [2:0] REG_RIGHT  = 3'd2;
  localparam logic [2:0] REG_TOP    = 3'd3;
  localparam logic [2:0] REG_SPAN   = 3'd4;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } req_t;

  typedef struct packed {
    logic signed [CW-1:0] seg_ax;
    logic signed [CW-1:0] seg_ay;
    logic signed [CW-1:0] seg_bx;
    logic signed [CW-1:0] seg_by;
    logic                 last_piece;
  } res_t;

  // bisection mode carried along the chain
  typedef enum logic [1:0] {
    MODE_TOWARD = 2'd0,  // p inside, keep inside midpoints in p
    MODE_SEARCH = 2'd1,  // both outside, look for an inside midpoint
    MODE_DONE   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_SEARCHED, ST_RUN_B, ST_EMIT2
  } state_t;
endpackage

@@ rtl/core/mslc_cell.sv @@
// One bisection step of the chain: while the span exceeds span_lim, halves a bracket and picks a side.
module mslc_cell import mslc_pkg::*; #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic signed [W-1:0] left,
  input  logic signed [W-1:0] bottom,
  input  logic signed [W-1:0] right,
  input  logic signed [W-1:0] top,
  input  logic        [W:0]   span_lim,
  input  mode_t               mode_in,
  input  logic signed [W-1:0] px_in,
  input  logic signed [W-1:0] py_in,
  input  logic signed [W-1:0] qx_in,
  input  logic signed [W-1:0] qy_in,
  output mode_t               mode_out,
  output logic signed [W-1:0] px_out,
  output logic signed [W-1:0] py_out,
  output logic signed [W-1:0] qx_out,
  output logic signed [W-1:0] qy_out
);
  logic signed [W:0]   sx, sy, dx, dy;
  logic signed [W-1:0] mx, my;
  logic [W:0]          ax, ay;
  logic [W+1:0]        spn;
  logic [3:0]          cm, cp;
  logic                big;
  mode_t               mode_n;
  logic signed [W-1:0] px_n, py_n, qx_n, qy_n;

  function automatic logic [3:0] ocode(input logic signed [W-1:0] x,
                                       input logic signed [W-1:0] y,
                                       input logic signed [W-1:0] l,
                                       input logic signed [W-1:0] b,
                                       input logic signed [W-1:0] r,
                                       input logic signed [W-1:0] t);
    logic [3:0] c;
    c = 4'd0;
    if (x < l) c = c | OC_LEFT;
    else if (x > r) c = c | OC_RIGHT;
    if (y < b) c = c | OC_BOTTOM;
    else if (y > t) c = c | OC_TOP;
    return c;
  endfunction

  always_comb begin
    sx = {px_in[W-1], px_in} + {qx_in[W-1], qx_in};
    sy = {py_in[W-1], py_in} + {qy_in[W-1], qy_in};
    mx = sx[W:1];  // arithmetic shift = floor halving
    my = sy[W:1];
    dx = {px_in[W-1], px_in} - {qx_in[W-1], qx_in};
    dy = {py_in[W-1], py_in} - {qy_in[W-1], qy_in};
    ax = dx[W] ? (W+1)'(-dx) : dx;
    ay = dy[W] ? (W+1)'(-dy) : dy;
    spn = {1'b0, ax} + {1'b0, ay};
    big = spn > {1'b0, span_lim};
    cm = ocode(mx, my, left, bottom, right, top);
    cp = ocode(px_in, py_in, left, bottom, right, top);
    mode_n = mode_in;
    px_n = px_in; py_n = py_in; qx_n = qx_in; qy_n = qy_in;
    unique case (mode_in)
      MODE_TOWARD: begin
        if (big) begin
          if (cm == 4'd0) begin px_n = mx; py_n = my; end
          else begin qx_n = mx; qy_n = my; end
        end
      end
      MODE_SEARCH: begin
        // the search step; the midpoint is recomputed downstream
        if (cm != 4'd0 && big) begin
          if ((cp & cm) != 4'd0) begin px_n = mx; py_n = my; end
          else begin qx_n = mx; qy_n = my; end
        end else begin
          mode_n = MODE_DONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mode_out <= mode_n;
    px_out <= px_n; py_out <= py_n; qx_out <= qx_n; qy_out <= qy_n;
  end
endmodule

@@ rtl/core/mslc_chain.sv @@
// Row of bisection cells, one step per cell, registered between cells.
module mslc_chain import mslc_pkg::*; #(
  parameter int W = 16,
  parameter int N = W + 1
) (
  input  logic                clk,
  input  logic signed [W-1:0] left,
  input  logic signed [W-1:0] bottom,
  input  logic signed [W-1:0] right,
  input  logic signed [W-1:0] top,
  input  logic        [W:0]   span_lim,
  input  mode_t               mode_in,
  input  logic signed [W-1:0] px_in,
  input  logic signed [W-1:0] py_in,
  input  logic signed [W-1:0] qx_in,
  input  logic signed [W-1:0] qy_in,
  output mode_t               mode_out,
  output logic signed [W-1:0] px_out,
  output logic signed [W-1:0] py_out,
  output logic signed [W-1:0] qx_out,
  output logic signed [W-1:0] qy_out
);
  mode_t               md [N+1];
  logic signed [W-1:0] px [N+1];
  logic signed [W-1:0] py [N+1];
  logic signed [W-1:0] qx [N+1];
  logic signed [W-1:0] qy [N+1];

  assign md[0] = mode_in;
  assign px[0] = px_in;
  assign py[0] = py_in;
  assign qx[0] = qx_in;
  assign qy[0] = qy_in;

  for (genvar i = 0; i < N; i++) begin : g_cell
    mslc_cell #(.W(W)) u_cell (
      .clk, .left, .bottom, .right, .top, .span_lim,
      .mode_in(md[i]), .px_in(px[i]), .py_in(py[i]), .qx_in(qx[i]), .qy_in(qy[i]),
      .mode_out(md[i+1]), .px_out(px[i+1]), .py_out(py[i+1]),
      .qx_out(qx[i+1]), .qy_out(qy[i+1])
    );
  end

  assign mode_out = md[N];
  assign px_out = px[N];
  assign py_out = py[N];
  assign qx_out = qx[N];
  assign qy_out = qy[N];
endmodule

@@ rtl/core/midpoint_subdivision_line_clip_unit.sv @@
// Top level of the midpoint subdivision line clip unit.
// Usage:
//   Pulse start with a segment on req while busy is low; the request is
//   taken at that edge. busy stays high until the last piece is out.
//   Results appear on res for one cycle each, marked by done; res.last_piece
//   flags the final piece of a segment. Segments with no visible part give
//   no result at all.
//   Bisection runs through a chain of COORD_BITS+1 cells, one step per cell.
//   When both ends are inside, the result is registered straight from req; a
//   trivially rejected segment gives nothing. One inside end takes one pass
//   of the chain; two outside ends take the search pass plus two passes of
//   the chain, with the first piece after the first and the last after the second.
//   After a bisected segment the next is taken once the block has left ST_EMIT2,
//   which follows its last result; otherwise it can be taken at the next edge.
//   The chain latency sets the throughput; one segment is in flight.
//   Config: cfg_we writes cfg_data into register cfg_index at any edge;
//   write only while busy is low.
//   Reset (rst, synchronous) restores the default rectangle -100..100 by
//   -80..80 and tolerance 2, and idles the block. The receiver cannot stall.
`include "midpoint_subdivision_line_clip_unit_macros.svh"
module midpoint_subdivision_line_clip_unit import mslc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  done,
  output res_t                  res,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [COORD_BITS:0]   cfg_data
);
  localparam int W = COORD_BITS;
  localparam int LAT = W + 1;
  localparam int CB = $clog2(LAT + 1);

  logic signed [W-1:0] left, bottom, right, top;
  logic [W:0]          span_lim;

  state_t state, state_next;
  logic [CB-1:0] cnt, cnt_next;

  // held geometry
  logic signed [W-1:0] ax, ay, bx, by;      // piece start and far point
  logic signed [W-1:0] ax_next, ay_next, bx_next, by_next;

  mode_t               c_mode_in, c_mode_out;
  logic signed [W-1:0] c_px, c_py, c_qx, c_qy;
  logic signed [W-1:0] o_px, o_py, o_qx, o_qy;

  logic signed [W-1:0] sx, sy, ex, ey;
  logic [3:0]          c1, c2, cmo;
  logic signed [W:0]   smx, smy;
  logic signed [W-1:0] mx, my;
  logic                acc;
  res_t                res_next;
  logic                done_next;

  function automatic logic [3:0] ocode(input logic signed [W-1:0] x,
                                       input logic signed [W-1:0] y,
                                       input logic signed [W-1:0] l,
                                       input logic signed [W-1:0] b,
                                       input logic signed [W-1:0] r,
                                       input logic signed [W-1:0] t);
    logic [3:0] c;
    c = 4'd0;
    if (x < l) c = c | OC_LEFT;
    else if (x > r) c = c | OC_RIGHT;
    if (y < b) c = c | OC_BOTTOM;
    else if (y > t) c = c | OC_TOP;
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= -W'(100); bottom <= -W'(80); right <= W'(100); top <= W'(80);
      span_lim <= (W+1)'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT:   left <= cfg_data[W-1:0];
        REG_BOTTOM: bottom <= cfg_data[W-1:0];
        REG_RIGHT:  right <= cfg_data[W-1:0];
        REG_TOP:    top <= cfg_data[W-1:0];
        REG_SPAN:   span_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sx = req.start_x[W-1:0];
  assign sy = req.start_y[W-1:0];
  assign ex = req.end_x[W-1:0];
  assign ey = req.end_y[W-1:0];
  assign c1 = ocode(sx, sy, left, bottom, right, top);
  assign c2 = ocode(ex, ey, left, bottom, right, top);
  assign busy = (state != ST_IDLE);
  assign acc = start && !busy;

  // midpoint of the searched bracket
  assign smx = {o_px[W-1], o_px} + {o_qx[W-1], o_qx};
  assign smy = {o_py[W-1], o_py} + {o_qy[W-1], o_qy};
  assign mx = smx[W:1];
  assign my = smy[W:1];
  assign cmo = ocode(mx, my, left, bottom, right, top);

  mslc_chain #(.W(W), .N(LAT)) u_chain (
    .clk, .left, .bottom, .right, .top, .span_lim,
    .mode_in(c_mode_in), .px_in(c_px), .py_in(c_py), .qx_in(c_qx), .qy_in(c_qy),
    .mode_out(c_mode_out), .px_out(o_px), .py_out(o_py), .qx_out(o_qx), .qy_out(o_qy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      done <= done_next;
    end
    ax <= ax_next; ay <= ay_next; bx <= bx_next; by <= by_next;
    res <= res_next;
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    done_next = 1'b0;
    res_next = res;
    ax_next = ax; ay_next = ay; bx_next = bx; by_next = by;
    c_mode_in = MODE_DONE;
    c_px = ax; c_py = ay; c_qx = bx; c_qy = by;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (c1 == 4'd0 && c2 == 4'd0) begin
            done_next = 1'b1;
            res_next = '{seg_ax: sx, seg_ay: sy, seg_bx: ex, seg_by: ey, last_piece: 1'b1};
          end else if ((c1 & c2) != 4'd0) begin
            state_next = ST_IDLE;
          end else if (c1 == 4'd0 || c2 == 4'd0) begin
            c_mode_in = MODE_TOWARD;
            c_px = (c1 == 4'd0) ? sx : ex; c_py = (c1 == 4'd0) ? sy : ey;
            c_qx = (c1 == 4'd0) ? ex : sx; c_qy = (c1 == 4'd0) ? ey : sy;
            ax_next = c_px; ay_next = c_py;
            state_next = ST_RUN_B;
            cnt_next = CB'(LAT - 1);
          end else begin
            c_mode_in = MODE_SEARCH;
            c_px = sx; c_py = sy; c_qx = ex; c_qy = ey;
            state_next = ST_RUN;
            cnt_next = CB'(LAT - 1);
          end
        end
      end
      ST_RUN: begin
        if (cnt == '0) begin
          if (cmo != 4'd0) begin
            state_next = ST_IDLE;
          end else begin
            // launch toward p now, keep q for the second pass
            c_mode_in = MODE_TOWARD;
            c_px = mx; c_py = my; c_qx = o_px; c_qy = o_py;
            ax_next = mx; ay_next = my; bx_next = o_qx; by_next = o_qy;
            state_next = ST_SEARCHED;
            cnt_next = CB'(LAT - 1);
          end
        end else cnt_next = cnt - 1'b1;
      end
      ST_SEARCHED: begin
        if (cnt == '0) begin
          c_mode_in = MODE_TOWARD;
          c_px = ax; c_py = ay; c_qx = bx; c_qy = by;
          done_next = 1'b1;
          res_next = '{seg_ax: ax, seg_ay: ay, seg_bx: o_px, seg_by: o_py, last_piece: 1'b0};
          state_next = ST_RUN_B;
          cnt_next = CB'(LAT - 1);
        end else cnt_next = cnt - 1'b1;
      end
      ST_RUN_B: begin
        if (cnt == '0) begin
          done_next = 1'b1;
          res_next = '{seg_ax: ax, seg_ay: ay, seg_bx: o_px, seg_by: o_py, last_piece: 1'b1};
          state_next = ST_EMIT2;
        end else cnt_next = cnt - 1'b1;
      end
      ST_EMIT2: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  `MSLC_ASSERT_NEXT(a_no_done_idle_acc, clk, rst, !busy && !start, !done || $past(busy), "result without request")
  `MSLC_ASSERT_IMPL(a_cnt_range, clk, rst, cnt <= CB'(LAT - 1), "counter out of range")
  `MSLC_ASSERT_NEXT(a_last_ends, clk, rst, done && res.last_piece && $past(state) == ST_RUN_B, !done, "piece after last")
  `MSLC_ASSERT_IMPL(a_walk_mode, clk, rst, state != ST_RUN_B || cnt != '0 || c_mode_out == MODE_TOWARD, "walk lost its mode")
endmodule
